@@ rtl/core/slt_pkg.sv @@
// Shared types, codes and keyword tables of the small language tokenizer.
package slt_pkg;

	localparam int unsigned MAX_NAME = 1024;
	localparam int unsigned LEN_W = 11;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned QUEUE_DEPTH = 3;

	typedef enum logic [4:0] {
		K_PLUS    = 5'd0,
		K_MINUS   = 5'd1,
		K_MULT    = 5'd2,
		K_DIV     = 5'd3,
		K_LT      = 5'd4,
		K_GT      = 5'd5,
		K_EQ      = 5'd6,
		K_NEQ     = 5'd7,
		K_ASSIGN  = 5'd8,
		K_LPAREN  = 5'd9,
		K_RPAREN  = 5'd10,
		K_NUMBER  = 5'd11,
		K_IDENT   = 5'd12,
		K_FOR     = 5'd13,
		K_DEFAULT = 5'd14,
		K_WRITE   = 5'd15,
		K_LBRACE  = 5'd16,
		K_RBRACE  = 5'd17,
		K_READ    = 5'd18,
		K_SEMI    = 5'd19,
		K_END     = 5'd20,
		K_UNKNOWN = 5'd21
	} tok_kind_t;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_EQ   = 3'd1,
		MODE_BANG = 3'd2,
		MODE_NUM  = 3'd3,
		MODE_NAME = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		KW_NONE    = 3'd0,
		KW_FOR     = 3'd1,
		KW_DEFAULT = 3'd2,
		KW_WRITE   = 3'd3,
		KW_READ    = 3'd4
	} kw_t;

	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	typedef struct packed {
		tok_kind_t          kind;
		logic [VAL_W-1:0]   number_value;
		logic [LEN_W-1:0]   name_length;
		logic               last_of_run;
	} token_t;

	// Tokens handed from the lexer to the output queue at once: up to two, counted by n.
	typedef struct packed {
		logic [1:0]       n;
		token_t [1:0]     tok;
	} push_t;

	typedef struct packed {
		mode_t              mode;
		logic [VAL_W-1:0]   acc;
		logic [LEN_W-1:0]   count;
		kw_t                cand;
	} lex_state_t;

	localparam lex_state_t IDLE_STATE = '{MODE_IDLE, '0, '0, KW_NONE};

	function automatic token_t make_tok(tok_kind_t kind, logic [VAL_W-1:0] val,
			logic [LEN_W-1:0] len);
		token_t t;
		t.kind = kind;
		t.number_value = val;
		t.name_length = len;
		t.last_of_run = 1'b0;
		return t;
	endfunction

	function automatic logic [3:0] kw_len(kw_t k);
		logic [3:0] r;
		case (k)
			KW_FOR:     r = 4'd3;
			KW_DEFAULT: r = 4'd7;
			KW_WRITE:   r = 4'd5;
			KW_READ:    r = 4'd4;
			default:    r = 4'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] kw_char(kw_t k, logic [2:0] pos);
		logic [7:0] r;
		logic [7:0][7:0] txt;
		case (k)
			KW_FOR:     txt = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "r", "o", "f"};
			KW_DEFAULT: txt = {8'h00, "t", "l", "u", "a", "f", "e", "d"};
			KW_WRITE:   txt = {8'h00, 8'h00, 8'h00, "e", "t", "i", "r", "w"};
			KW_READ:    txt = {8'h00, 8'h00, 8'h00, 8'h00, "d", "a", "e", "r"};
			default:    txt = '0;
		endcase
		r = txt[pos];
		return r;
	endfunction

	function automatic tok_kind_t kw_kind(kw_t k);
		tok_kind_t r;
		case (k)
			KW_FOR:     r = K_FOR;
			KW_DEFAULT: r = K_DEFAULT;
			KW_WRITE:   r = K_WRITE;
			KW_READ:    r = K_READ;
			default:    r = K_IDENT;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/slt_if.sv @@
// Handshake interfaces for the character input and the token output channels.
interface slt_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_mark;

	modport source (output valid, output char_code, output end_mark, input ready);
	modport sink (input valid, input char_code, input end_mark, output ready);
endinterface

interface slt_token_if;
	logic                 valid;
	logic                 ready;
	logic [4:0]           token_kind;
	logic signed [31:0]   number_value;
	logic [10:0]          name_length;
	logic                 last_of_run;

	modport source (output valid, output token_kind, output number_value,
		output name_length, output last_of_run, input ready);
	modport sink (input valid, input token_kind, input number_value,
		input name_length, input last_of_run, output ready);
endinterface

@@ rtl/core/slt_lexer.sv @@
// Lexer state registers and the single-step token logic for one character.
module slt_lexer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      char_code,
	input  logic            end_mark,
	output slt_pkg::push_t  push
);

	typedef struct packed {
		logic                 emit;
		slt_pkg::tok_kind_t   kind;
		slt_pkg::lex_state_t  st;
	} fresh_t;

	slt_pkg::lex_state_t st_q;
	slt_pkg::lex_state_t st_nxt;
	slt_pkg::lex_state_t ext_st;
	fresh_t              fr;
	slt_pkg::token_t     tok_a;
	slt_pkg::token_t     tok_b;
	logic                a_v;
	logic                b_v;
	logic                do_fresh;
	logic                is_digit;
	logic                is_word;

	function automatic fresh_t fresh_char(logic [7:0] c);
		fresh_t r;
		r.emit = 1'b0;
		r.kind = slt_pkg::K_UNKNOWN;
		r.st = slt_pkg::IDLE_STATE;
		if (c == " " || (c >= 8'h09 && c <= 8'h0D)) begin
			r.emit = 1'b0;
		end else begin
			case (c)
				"+": begin r.emit = 1'b1; r.kind = slt_pkg::K_PLUS; end
				"-": begin r.emit = 1'b1; r.kind = slt_pkg::K_MINUS; end
				"*": begin r.emit = 1'b1; r.kind = slt_pkg::K_MULT; end
				"/": begin r.emit = 1'b1; r.kind = slt_pkg::K_DIV; end
				"<": begin r.emit = 1'b1; r.kind = slt_pkg::K_LT; end
				">": begin r.emit = 1'b1; r.kind = slt_pkg::K_GT; end
				"(": begin r.emit = 1'b1; r.kind = slt_pkg::K_LPAREN; end
				")": begin r.emit = 1'b1; r.kind = slt_pkg::K_RPAREN; end
				"{": begin r.emit = 1'b1; r.kind = slt_pkg::K_LBRACE; end
				"}": begin r.emit = 1'b1; r.kind = slt_pkg::K_RBRACE; end
				";": begin r.emit = 1'b1; r.kind = slt_pkg::K_SEMI; end
				slt_pkg::CH_EQ:   r.st.mode = slt_pkg::MODE_EQ;
				slt_pkg::CH_BANG: r.st.mode = slt_pkg::MODE_BANG;
				default: begin
					if (c >= "0" && c <= "9") begin
						r.st.mode = slt_pkg::MODE_NUM;
						r.st.acc = {28'd0, c[3:0]};
					end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
							c == slt_pkg::CH_UNDER) begin
						r.st.mode = slt_pkg::MODE_NAME;
						r.st.count = 11'd1;
						case (c)
							"f":     r.st.cand = slt_pkg::KW_FOR;
							"d":     r.st.cand = slt_pkg::KW_DEFAULT;
							"w":     r.st.cand = slt_pkg::KW_WRITE;
							"r":     r.st.cand = slt_pkg::KW_READ;
							default: r.st.cand = slt_pkg::KW_NONE;
						endcase
					end else begin
						r.emit = 1'b1;
					end
				end
			endcase
		end
		return r;
	endfunction

	function automatic slt_pkg::token_t name_tok(slt_pkg::lex_state_t s);
		slt_pkg::tok_kind_t k;
		k = slt_pkg::K_IDENT;
		if (s.cand != slt_pkg::KW_NONE && s.count == {7'd0, slt_pkg::kw_len(s.cand)})
			k = slt_pkg::kw_kind(s.cand);
		return slt_pkg::make_tok(k, '0, s.count);
	endfunction

	assign fr = fresh_char(char_code);
	assign is_digit = char_code >= "0" && char_code <= "9";
	assign is_word = is_digit || char_code == slt_pkg::CH_UNDER ||
		(char_code >= "a" && char_code <= "z") || (char_code >= "A" && char_code <= "Z");

	// Name continuation: drop the keyword candidate once the text departs from it.
	always_comb begin
		ext_st = st_q;
		if (st_q.cand == slt_pkg::KW_NONE ||
				st_q.count >= {7'd0, slt_pkg::kw_len(st_q.cand)} ||
				slt_pkg::kw_char(st_q.cand, st_q.count[2:0]) != char_code)
			ext_st.cand = slt_pkg::KW_NONE;
		if (st_q.count < slt_pkg::LEN_W'(slt_pkg::MAX_NAME))
			ext_st.count = st_q.count + 11'd1;
	end

	always_comb begin
		st_nxt = slt_pkg::IDLE_STATE;
		a_v = 1'b0;
		tok_a = slt_pkg::make_tok(slt_pkg::K_UNKNOWN, '0, '0);
		do_fresh = 1'b0;
		if (end_mark) begin
			unique case (st_q.mode)
				slt_pkg::MODE_EQ: begin
					a_v = 1'b1;
					tok_a = slt_pkg::make_tok(slt_pkg::K_ASSIGN, '0, '0);
				end
				slt_pkg::MODE_BANG: a_v = 1'b1;
				slt_pkg::MODE_NUM: begin
					a_v = 1'b1;
					tok_a = slt_pkg::make_tok(slt_pkg::K_NUMBER, st_q.acc, '0);
				end
				slt_pkg::MODE_NAME: begin
					a_v = 1'b1;
					tok_a = name_tok(st_q);
				end
				default: a_v = 1'b0;
			endcase
		end else begin
			unique case (st_q.mode)
				slt_pkg::MODE_EQ: begin
					a_v = 1'b1;
					if (char_code == slt_pkg::CH_EQ) begin
						tok_a = slt_pkg::make_tok(slt_pkg::K_EQ, '0, '0);
					end else begin
						tok_a = slt_pkg::make_tok(slt_pkg::K_ASSIGN, '0, '0);
						do_fresh = 1'b1;
					end
				end
				slt_pkg::MODE_BANG: begin
					a_v = 1'b1;
					if (char_code == slt_pkg::CH_EQ)
						tok_a = slt_pkg::make_tok(slt_pkg::K_NEQ, '0, '0);
					else
						do_fresh = 1'b1;
				end
				slt_pkg::MODE_NUM: begin
					if (is_digit) begin
						st_nxt = st_q;
						st_nxt.acc = (st_q.acc << 3) + (st_q.acc << 1) +
							{28'd0, char_code[3:0]};
					end else begin
						a_v = 1'b1;
						tok_a = slt_pkg::make_tok(slt_pkg::K_NUMBER, st_q.acc, '0);
						do_fresh = 1'b1;
					end
				end
				slt_pkg::MODE_NAME: begin
					if (is_word) begin
						st_nxt = ext_st;
					end else begin
						a_v = 1'b1;
						tok_a = name_tok(st_q);
						do_fresh = 1'b1;
					end
				end
				default: do_fresh = 1'b1;
			endcase
			if (do_fresh)
				st_nxt = fr.st;
		end
	end

	assign b_v = end_mark || (do_fresh && fr.emit);
	assign tok_b = slt_pkg::make_tok(end_mark ? slt_pkg::K_END : fr.kind, '0, '0);

	always_comb begin
		push.n = 2'd0;
		push.tok[0] = tok_a;
		push.tok[1] = tok_b;
		if (a_v && b_v) begin
			push.n = 2'd2;
			push.tok[1].last_of_run = 1'b1;
		end else if (a_v) begin
			push.n = 2'd1;
			push.tok[0].last_of_run = 1'b1;
		end else if (b_v) begin
			push.n = 2'd1;
			push.tok[0] = tok_b;
			push.tok[0].last_of_run = 1'b1;
		end
		if (!accept)
			push.n = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= slt_pkg::IDLE_STATE;
		end else if (accept) begin
			st_q <= st_nxt;
		end
	end

endmodule

@@ rtl/core/slt_token_queue.sv @@
// Short shifting token queue: takes up to two tokens a cycle, delivers one while out_ready is high.
module slt_token_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  slt_pkg::push_t   push,
	output logic             has_room,
	output logic             out_valid,
	input  logic             out_ready,
	output slt_pkg::token_t  out_tok
);

	slt_pkg::token_t q_q [slt_pkg::QUEUE_DEPTH];
	slt_pkg::token_t q_nxt [slt_pkg::QUEUE_DEPTH];
	logic [1:0]      cnt_q;
	logic [1:0]      base;
	logic            pop;

	assign out_valid = cnt_q != 2'd0;
	assign out_tok = q_q[0];
	assign pop = out_valid && out_ready;
	// Room for a full two-token transaction is kept before taking a character.
	assign has_room = cnt_q <= 2'(slt_pkg::QUEUE_DEPTH - 2);
	assign base = cnt_q - {1'b0, pop};

	always_comb begin
		for (int i = 0; i < slt_pkg::QUEUE_DEPTH; i++) begin
			if (pop && i < slt_pkg::QUEUE_DEPTH - 1)
				q_nxt[i] = q_q[i + 1];
			else
				q_nxt[i] = q_q[i];
			if (push.n != 2'd0 && 2'(i) == base)
				q_nxt[i] = push.tok[0];
			if (push.n == 2'd2 && 2'(i) == base + 2'd1)
				q_nxt[i] = push.tok[1];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < slt_pkg::QUEUE_DEPTH; i++)
			q_q[i] <= q_nxt[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= base + push.n;
		end
	end

endmodule

@@ rtl/core/small_language_tokenizer_unit.sv @@
// Top level of the small language tokenizer.
// One character (or end mark) is taken per transaction and yields zero, one or two
// tokens, each delivered as its own output transaction with last_of_run set on the
// final token of that character. The lexer state updates in the cycle a character is
// accepted; its tokens are registered in a three-entry token queue and reach the
// output behind any tokens still waiting. Input ready stays high while the queue
// holds at most one token, so a stream that yields up to one token per character
// runs at one character per cycle while the output is ready, and characters that
// yield two tokens (a pending token closed by an operator, or a flush before the end
// token) hold off input until a token is taken. There are no configuration registers.
module small_language_tokenizer_unit (
	input  logic         clk,
	input  logic         arst_n,
	slt_char_if.sink     char_in,
	slt_token_if.source  token_out
);

	slt_pkg::push_t  push;
	slt_pkg::token_t out_tok;
	logic            has_room;
	logic            accept;

	assign char_in.ready = has_room;
	assign accept = char_in.valid && has_room;

	slt_lexer u_lexer (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.char_code (char_in.char_code),
		.end_mark  (char_in.end_mark),
		.push      (push)
	);

	slt_token_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.has_room  (has_room),
		.out_valid (token_out.valid),
		.out_ready (token_out.ready),
		.out_tok   (out_tok)
	);

	assign token_out.token_kind = out_tok.kind;
	assign token_out.number_value = out_tok.number_value;
	assign token_out.name_length = out_tok.name_length;
	assign token_out.last_of_run = out_tok.last_of_run;

endmodule

@@ rtl/core/slt_checker.sv @@
// Port-level checks on the tokenizer top level, attached by bind.
module slt_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_end_mark,
	input logic out_valid,
	input logic out_ready,
	input logic out_last
);

	// An end mark always yields at least the end token.
	a_end_gives_token: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_end_mark |=> out_valid)
		else $error("no token after accepted end mark");

	// Input is only held off while tokens wait to be taken.
	a_stall_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no token pending");

	// A token that is not last in its run is followed at once by the rest.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid)
		else $error("token run broken");

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output transaction withdrawn");

endmodule

bind small_language_tokenizer_unit slt_checker u_slt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (char_in.valid),
	.in_ready    (char_in.ready),
	.in_end_mark (char_in.end_mark),
	.out_valid   (token_out.valid),
	.out_ready   (token_out.ready),
	.out_last    (token_out.last_of_run)
);
